/* hdl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define CHECK_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define CHECK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// Invariant checked on every rising edge outside reset.
`define CHECK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`endif

/* hdl/bla_pkg.sv */
// ----------------------------------------------------------------------------
// bla_pkg
// Types and constants for the battery level averager: word formats, charger
// status codes and the fixed-point limits of the percentage curve.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bla_pkg;

  localparam int WINDOW_LEN_DEF = 60;

  localparam int CODE_W   = 12;
  localparam int LEVEL_W  = 7;
  localparam int MV_W     = 13;
  localparam int STATUS_W = 2;

  // Limits on code*66 (volts * 4095 * 10).
  localparam logic [18:0] SCALED_EMPTY = 19'd131040;  // 3.2 V
  localparam logic [18:0] SCALED_FULL  = 19'd171990;  // 4.2 V
  localparam logic [18:0] SCALED_DISC  = 19'd102375;  // 2.5 V

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

  localparam logic [STATUS_W-1:0] STATUS_DISCONNECTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CHARGING     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_DISCHARGING  = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] adc_code;
    logic              stat_one;
    logic              stat_two;
  } sample_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]  level_percent;
    logic [MV_W-1:0]     battery_millivolts;
    logic [STATUS_W-1:0] charge_status;
  } result_word_t;

endpackage

/* hdl/battery_level_averager.sv */
// An accepted sample word passes stages 1 to 5 and the output register.
// Throughput: one word per cycle when not stalled; the ring memory is read one
// stage ahead of its write-back, so consecutive words never touch the same entry.
// Reset clears the pipeline, ring position and running total, and the ring's
// per-entry valid bits at once: no clearing pass, samples accepted right away.
// ----------------------------------------------------------------------------
// battery_level_averager
// Battery gauge: millivolts, charger status and a moving-average charge
// percentage over a ring of WINDOW_LEN samples kept as a running sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module battery_level_averager
  import bla_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         sample_valid,
  output logic         sample_ready,
  input  sample_word_t sample,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result
);

  localparam int AW     = $clog2(WINDOW_LEN);
  localparam int TOT_W  = $clog2(WINDOW_LEN * 100 + 1);
  localparam int RSHIFT = TOT_W + $clog2(WINDOW_LEN);
  localparam int RCP_W  = TOT_W + 2;
  localparam int PROD_W = TOT_W + RCP_W;
  localparam longint unsigned RCP_VAL =
    ((longint'(1) << RSHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(RCP_VAL);
  localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_LEN - 1);
  localparam logic [TOT_W-1:0] TOT_MAX = TOT_W'(WINDOW_LEN * 100);

  // Stage enables, back to front.
  logic en1, en2, en3, en4, en5, en6;

  // Stage 1: captured word.
  logic              s1_vld;
  logic [CODE_W-1:0] s1_code;
  logic              s1_one;
  logic              s1_two;

  // Stage 2: scaled products and limit flags.
  logic                s2_vld;
  logic                s2_lo;
  logic                s2_hi;
  logic [20:0]         s2_xp;
  logic [24:0]         s2_xm;
  logic [STATUS_W-1:0] s2_stat;

  // Stage 3: quotient estimates by 4095.
  logic                s3_vld;
  logic                s3_lo;
  logic                s3_hi;
  logic [20:0]         s3_xp;
  logic [24:0]         s3_xm;
  logic [9:0]          s3_tp;
  logic [MV_W-1:0]     s3_tm;
  logic [STATUS_W-1:0] s3_stat;

  // Stage 4: final values, ring entry being read.
  logic                s4_vld;
  logic [LEVEL_W-1:0]  s4_pct;
  logic [MV_W-1:0]     s4_mv;
  logic [STATUS_W-1:0] s4_stat;
  logic [AW-1:0]       s4_addr;

  // Stage 5: running total snapshot.
  logic                s5_vld;
  logic [TOT_W-1:0]    s5_total;
  logic [MV_W-1:0]     s5_mv;
  logic [STATUS_W-1:0] s5_stat;

  // Output register.
  logic         out_vld;
  result_word_t out_word;

  // Ring state.
  logic [LEVEL_W-1:0] ring [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] ring_vld;
  logic [LEVEL_W-1:0] rd_level;
  logic               rd_hit;
  logic [AW-1:0]      pos;
  logic [AW-1:0]      rd_addr;
  logic [TOT_W-1:0]   total;
  logic [TOT_W-1:0]   total_next;
  logic [LEVEL_W-1:0] old_level;

  // Combinational datapath.
  logic [18:0]         sc66;
  logic [20:0]         xp;
  logic [24:0]         xm;
  logic [STATUS_W-1:0] stat;
  logic [21:0]         sum_p;
  logic [25:0]         sum_m;
  logic [13:0]         rem_p;
  logic [13:0]         rem_m;
  logic [9:0]          q_p;
  logic [LEVEL_W-1:0]  pct;
  logic [MV_W-1:0]     mv;
  logic [PROD_W-1:0]   prod;

  assign en6 = !out_vld || result_ready;
  assign en5 = !s5_vld || en6;
  assign en4 = !s4_vld || en5;
  assign en3 = !s3_vld || en4;
  assign en2 = !s2_vld || en3;
  assign en1 = !s1_vld || en2;

  assign sample_ready = en1;
  assign result_valid = out_vld;
  assign result       = out_word;

  // Products and flags.
  always_comb begin
    sc66 = {7'd0, s1_code} * 19'd66;
    xp   = ({9'd0, s1_code} * 21'd660) - 21'd1310400;
    xm   = {13'd0, s1_code} * 25'd6600;
    if (sc66 < SCALED_DISC) begin
      stat = STATUS_DISCONNECTED;
    end else if (s1_one && !s1_two) begin
      stat = STATUS_FULL;
    end else if (s1_one && s1_two) begin
      stat = STATUS_DISCHARGING;
    end else begin
      stat = STATUS_CHARGING;
    end
  end

  // Estimate x/4095 as (x + x/4096)/4096: low by at most one.
  assign sum_p = {1'b0, s2_xp} + {13'd0, s2_xp[20:12]};
  assign sum_m = {1'b0, s2_xm} + {13'd0, s2_xm[24:12]};

  // Remainder x - 4095*t lies in 0..8189, so 14 bits carry it exactly.
  always_comb begin
    rem_p = s3_xp[13:0] - {s3_tp[1:0], 12'd0} + {4'd0, s3_tp};
    rem_m = s3_xm[13:0] - {s3_tm[1:0], 12'd0} + {1'b0, s3_tm};
    q_p   = s3_tp + {9'd0, (rem_p >= 14'd4095)};
    mv    = s3_tm + {12'd0, (rem_m >= 14'd4095)};
    if (s3_lo) begin
      pct = '0;
    end else if (s3_hi) begin
      pct = LEVEL_MAX;
    end else begin
      pct = q_p[LEVEL_W-1:0];
    end
  end

  assign rd_addr    = (pos == LAST_POS) ? '0 : pos + 1'b1;
  assign old_level  = rd_hit ? rd_level : '0;
  assign total_next = total - {{(TOT_W-LEVEL_W){1'b0}}, old_level}
                    + {{(TOT_W-LEVEL_W){1'b0}}, s4_pct};

  // Mean by multiplying with a rounded-up reciprocal.
  assign prod = {{(PROD_W-TOT_W){1'b0}}, s5_total} * {{(PROD_W-RCP_W){1'b0}}, RECIP};

  // Stage valids and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld   <= 1'b0;
      s2_vld   <= 1'b0;
      s3_vld   <= 1'b0;
      s4_vld   <= 1'b0;
      s5_vld   <= 1'b0;
      out_vld  <= 1'b0;
      pos      <= '0;
      total    <= '0;
      ring_vld <= '0;
    end else begin
      if (en1) s1_vld  <= sample_valid;
      if (en2) s2_vld  <= s1_vld;
      if (en3) s3_vld  <= s2_vld;
      if (en4) s4_vld  <= s3_vld;
      if (en5) s5_vld  <= s4_vld;
      if (en6) out_vld <= s5_vld;
      // Advance the ring position as the entry is fetched.
      if (en4 && s3_vld) begin
        pos <= rd_addr;
      end
      if (en5 && s4_vld) begin
        total             <= total_next;
        ring_vld[s4_addr] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_code <= sample.adc_code;
      s1_one  <= sample.stat_one;
      s1_two  <= sample.stat_two;
    end
    if (en2) begin
      s2_lo   <= (sc66 <= SCALED_EMPTY);
      s2_hi   <= (sc66 >= SCALED_FULL);
      s2_xp   <= xp;
      s2_xm   <= xm;
      s2_stat <= stat;
    end
    if (en3) begin
      s3_lo   <= s2_lo;
      s3_hi   <= s2_hi;
      s3_xp   <= s2_xp;
      s3_xm   <= s2_xm;
      s3_tp   <= sum_p[21:12];
      s3_tm   <= sum_m[24:12];
      s3_stat <= s2_stat;
    end
    if (en4) begin
      s4_pct  <= pct;
      s4_mv   <= mv;
      s4_stat <= s3_stat;
      s4_addr <= rd_addr;
    end
    if (en5) begin
      s5_total <= total_next;
      s5_mv    <= s4_mv;
      s5_stat  <= s4_stat;
    end
    if (en6) begin
      out_word.level_percent      <= prod[RSHIFT +: LEVEL_W];
      out_word.battery_millivolts <= s5_mv;
      out_word.charge_status      <= s5_stat;
    end
  end

  // Ring memory: registered read, write-back one stage later.
  always_ff @(posedge clk) begin
    if (en4 && s3_vld) begin
      rd_level <= ring[rd_addr];
      rd_hit   <= ring_vld[rd_addr];
    end
    if (en5 && s4_vld) begin
      ring[s4_addr] <= s4_pct;
    end
  end

  `CHECK_ALWAYS(a_total_bound, total <= TOT_MAX, "running total beyond window maximum")
  `CHECK_IMPLY(a_no_same_entry, en4 && s3_vld && en5 && s4_vld, rd_addr != s4_addr,
    "ring read and write-back hit the same entry")
  `CHECK_NEXT(a_pos_hold, !(en4 && s3_vld), $stable(pos),
    "ring position moved without a fetch")
  `CHECK_IMPLY(a_level_bound, out_vld, out_word.level_percent <= LEVEL_MAX,
    "mean level above one hundred")
  `CHECK_IMPLY(a_pct_bound, s4_vld, s4_pct <= LEVEL_MAX, "sample level above one hundred")

endmodule

/* sim/tb_battery_level_averager.sv */
// ----------------------------------------------------------------------------
// tb_battery_level_averager
// Self-checking bench for the battery level averager. A short table of sample
// words covers the voltage thresholds and every charger pin combination. A
// long random run follows, banded so that the moving average reaches both
// ends. Every result word is checked field by field: typed rows against their
// table word, the rest against a behavioural gauge with its own level history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_battery_level_averager
  import bla_pkg::*;
;

  localparam int RANDOM_ITEMS  = 1630;
  localparam int HOLD_CYCLES   = 200;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 100000;
  localparam int IDLE_PERCENT  = 33;
  localparam int STEADY_FIRST  = 500;
  localparam int STEADY_LAST   = 800;
  localparam int HOLD_AT       = 300;
  localparam int PAUSE_AT      = 1000;
  localparam int HIST_AW       = $clog2(WINDOW_LEN_DEF);

  localparam logic [CODE_W-1:0] EDGE_CODES [8] = '{
    12'd0, 12'd1551, 12'd1552, 12'd1985, 12'd1986, 12'd2605, 12'd2606, 12'd4095
  };

  typedef enum int {
    BAND_ANY,
    BAND_LINEAR,
    BAND_HIGH,
    BAND_LOW,
    BAND_EDGE
  } code_band_t;

  typedef struct {
    sample_word_t word;
    bit           typed;
    result_word_t want;
  } stim_row_t;

  logic         clk;
  logic         rst;
  logic         sample_valid;
  logic         sample_ready;
  sample_word_t sample;
  logic         result_valid;
  logic         result_ready;
  result_word_t result;

  // Shared between sender, receiver and scoreboard.
  bit           steady;
  bit           hold_req;
  bit           cur_typed;
  result_word_t cur_want;

  // Gauge model state.
  logic [LEVEL_W-1:0] level_hist [WINDOW_LEN_DEF];
  logic [HIST_AW-1:0] hist_slot;
  int unsigned        hist_total;

  result_word_t pending_results [$];
  stim_row_t    stim_rows [$];
  int unsigned  error_count;
  int unsigned  cycle_count;

  battery_level_averager #(
    .WINDOW_LEN(WINDOW_LEN_DEF)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  // Advance the history ring, then work out the result word for this sample.
  function automatic result_word_t gauge_predict(input sample_word_t w);
    int unsigned  code;
    int unsigned  scaled;
    int unsigned  pct;
    int unsigned  mv;
    result_word_t r;
    code   = w.adc_code;
    scaled = code * 66;
    if (scaled <= SCALED_EMPTY) begin
      pct = 0;
    end else if (scaled >= SCALED_FULL) begin
      pct = LEVEL_MAX;
    end else begin
      pct = (code * 660 - 1310400) / 4095;
    end
    hist_slot              = (hist_slot == HIST_AW'(WINDOW_LEN_DEF - 1)) ? '0
                                                                          : hist_slot + 1'b1;
    hist_total             = hist_total - level_hist[hist_slot] + pct;
    level_hist[hist_slot]  = pct[LEVEL_W-1:0];
    mv                     = code * 6600 / 4095;
    r.level_percent        = LEVEL_W'(hist_total / WINDOW_LEN_DEF);
    r.battery_millivolts   = mv[MV_W-1:0];
    if (scaled < SCALED_DISC) begin
      r.charge_status = STATUS_DISCONNECTED;
    end else if (w.stat_one && !w.stat_two) begin
      r.charge_status = STATUS_FULL;
    end else if (w.stat_one && w.stat_two) begin
      r.charge_status = STATUS_DISCHARGING;
    end else begin
      r.charge_status = STATUS_CHARGING;
    end
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code(input code_band_t band);
    case (band)
      BAND_LINEAR: return CODE_W'($urandom_range(2605, 1986));
      BAND_HIGH:   return CODE_W'($urandom_range(4095, 2606));
      BAND_LOW:    return CODE_W'($urandom_range(1985, 0));
      BAND_EDGE:   return EDGE_CODES[3'($urandom_range(7))];
      default:     return CODE_W'($urandom_range(4095));
    endcase
  endfunction

  task automatic add_row(input int code, input bit s1, input bit s2, input bit typed,
                         input int lvl, input int mv, input logic [STATUS_W-1:0] st);
    stim_row_t row;
    row.word.adc_code            = CODE_W'(code);
    row.word.stat_one            = s1;
    row.word.stat_two            = s2;
    row.typed                    = typed;
    row.want.level_percent       = LEVEL_W'(lvl);
    row.want.battery_millivolts  = MV_W'(mv);
    row.want.charge_status       = st;
    stim_rows.push_back(row);
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so the next word can follow without a gap.
  task automatic offer_word(input sample_word_t w, input bit typed,
                            input result_word_t want);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    sample       = w;
    cur_typed    = typed;
    cur_want     = want;
    sample_valid = 1'b1;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cycle_count <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Score both channels at the rising edge.
  always @(posedge clk) begin
    result_word_t want;
    result_word_t model;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result word expected none actual %h", $time, result);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          report_field("level_percent", want.level_percent, result.level_percent);
          report_field("battery_millivolts", want.battery_millivolts,
                       result.battery_millivolts);
          report_field("charge_status", want.charge_status, result.charge_status);
        end
      end
      if (sample_valid && sample_ready) begin
        model = gauge_predict(sample);
        pending_results.push_back(cur_typed ? cur_want : model);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    result_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req     = 1'b0;
        result_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      result_ready = steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  initial begin
    sample_word_t w;
    code_band_t   band;
    int unsigned  sent;
    int unsigned  seg_len;
    sample_valid = 1'b0;
    sample       = '0;
    cur_typed    = 1'b0;
    cur_want     = '0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    error_count  = 0;
    hist_slot    = '0;
    hist_total   = 0;
    foreach (level_hist[i]) level_hist[i] = '0;

    // From reset, a zero row then full-scale rows: the average climbs by 100/WINDOW_LEN each.
    add_row(0,    0, 0, 1, 0, 0,    STATUS_DISCONNECTED);
    add_row(4095, 1, 1, 1, 1, 6600, STATUS_DISCHARGING);
    add_row(4095, 1, 0, 1, 3, 6600, STATUS_FULL);
    add_row(4095, 0, 0, 1, 5, 6600, STATUS_CHARGING);
    add_row(4095, 0, 1, 1, 6, 6600, STATUS_CHARGING);
    // Either side of 2.5 V, 3.2 V and 4.2 V.
    add_row(1551, 1, 0, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(1552, 1, 0, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(1552, 1, 1, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(1552, 0, 0, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(1985, 0, 1, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(1986, 1, 0, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(2605, 1, 1, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(2606, 1, 0, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(2300, 0, 1, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(2048, 1, 1, 0, 0, 0, STATUS_DISCONNECTED);
    // Pins high on a dead battery still read as disconnected; then mixed codes and pins.
    add_row(1,    1, 1, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(4094, 0, 0, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(2730, 1, 0, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(12'hAAA, 1, 0, 0, 0, 0, STATUS_DISCONNECTED);
    add_row(12'h555, 0, 1, 0, 0, 0, STATUS_DISCONNECTED);

    @(negedge rst);
    @(negedge clk);
    foreach (stim_rows[i]) offer_word(stim_rows[i].word, stim_rows[i].typed,
                                      stim_rows[i].want);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      band    = code_band_t'($urandom_range(BAND_EDGE));
      seg_len = $urandom_range(120, 1);
      repeat (seg_len) begin
        if (sent < RANDOM_ITEMS) begin
          steady = (sent >= STEADY_FIRST) && (sent < STEADY_LAST);
          if (sent == HOLD_AT) hold_req = 1'b1;
          if (sent == PAUSE_AT) begin
            // Drain the pipeline before offering more.
            sample_valid = 1'b0;
            while (pending_results.size() != 0) @(negedge clk);
          end
          w.adc_code = pick_code(band);
          w.stat_one = 1'($urandom_range(1));
          w.stat_two = 1'($urandom_range(1));
          offer_word(w, 1'b0, '0);
          sent++;
        end
      end
    end
    sample_valid = 1'b0;
    steady       = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
